>>> hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// same-cycle implication, sampled on clk, off while in reset
`define BLB_ASSERT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define BLB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

>>> hw/rtl/blb_pkg.sv
`timescale 1ns / 1ps
package blb_pkg;

    localparam int UP_W       = 16;
    localparam int WEIGHT_W   = 8;
    localparam int SUM_W      = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int DIV_W      = 32;
    localparam logic [31:0] ACTIVE_SAT = 32'hFFFF_FFFF;

    localparam logic [1:0] ACT_SELECT = 2'd0;
    localparam logic [1:0] ACT_START  = 2'd1;
    localparam logic [1:0] ACT_END    = 2'd2;

    localparam logic [2:0] MODE_RR     = 3'd0;
    localparam logic [2:0] MODE_LC     = 3'd1;
    localparam logic [2:0] MODE_HASH   = 3'd2;
    localparam logic [2:0] MODE_WEIGHT = 3'd3;
    localparam logic [2:0] MODE_RANDOM = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UP_MASK = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHTS_LO = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHTS_HI = 3'd5;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] client_hash;
        logic [31:0] random_word;
        logic [3:0]  backend_index;
    } in_item_t;

    typedef struct packed {
        logic        selection_valid;
        logic [3:0]  selected_backend;
        logic [31:0] active_count_now;
        logic [63:0] total_count_now;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_PROBE,
        ST_LC,
        ST_SUM,
        ST_PICK,
        ST_MEM_RD,
        ST_MEM_WR,
        ST_FIN
    } blb_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_CLEAR,
        OP_DIV_GO,
        OP_PROBE,
        OP_LC,
        OP_SUM,
        OP_PICK,
        OP_MEM_RD,
        OP_MEM_WR,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } ctrl_cmd_t;

    typedef struct packed {
        logic       is_select;
        logic       is_count;
        logic       sel_none;
        logic       in_range;
        logic [2:0] mode;
        logic       div_done;
        logic       step_done;
        logic       found;
        logic       out_free;
    } dp_stat_t;

endpackage

>>> hw/rtl/blb_ram.sv
`timescale 1ns / 1ps
module blb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hw/rtl/blb_div.sv
`timescale 1ns / 1ps
module blb_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [blb_pkg::DIV_W-1:0]    dividend,
    input  logic [blb_pkg::SUM_W-1:0]    divisor,
    output logic                         done,
    output logic [blb_pkg::SUM_W-1:0]    remainder
);

    localparam int CNT_W = $clog2(blb_pkg::DIV_W + 1);

    logic                        busy_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic                        done_reg;
    logic [blb_pkg::DIV_W-1:0]   q_reg;
    logic [blb_pkg::SUM_W:0]     r_reg;
    logic [blb_pkg::SUM_W-1:0]   d_reg;
    logic [blb_pkg::SUM_W:0]     r_shift;
    logic [blb_pkg::SUM_W:0]     r_next;

    // one quotient bit per cycle, restoring
    always_comb
    begin
        r_shift = {r_reg[blb_pkg::SUM_W-1:0], q_reg[blb_pkg::DIV_W-1]};
        if (r_shift >= {1'b0, d_reg})
        begin
            r_next = r_shift - {1'b0, d_reg};
        end
        else
        begin
            r_next = r_shift;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(blb_pkg::DIV_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg <= {q_reg[blb_pkg::DIV_W-2:0], 1'b0};
            r_reg <= r_next;
        end
    end

    assign done      = done_reg;
    assign remainder = r_reg[blb_pkg::SUM_W-1:0];

endmodule

>>> hw/rtl/blb_ctrl.sv
`timescale 1ns / 1ps
module blb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  blb_pkg::dp_stat_t stat,
    output blb_pkg::ctrl_cmd_t cmd
);

    blb_pkg::blb_state_t state_reg;
    blb_pkg::blb_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= blb_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            blb_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = blb_pkg::ST_DECODE;
                end
            end
            blb_pkg::ST_DECODE:
            begin
                if (stat.is_select)
                begin
                    if (stat.sel_none)
                    begin
                        state_next = blb_pkg::ST_FIN;
                    end
                    else
                    begin
                        case (stat.mode)
                            blb_pkg::MODE_RR,
                            blb_pkg::MODE_HASH:   state_next = blb_pkg::ST_DIV_GO;
                            blb_pkg::MODE_LC:     state_next = blb_pkg::ST_LC;
                            blb_pkg::MODE_WEIGHT,
                            blb_pkg::MODE_RANDOM: state_next = blb_pkg::ST_SUM;
                            default:              state_next = blb_pkg::ST_FIN;
                        endcase
                    end
                end
                else if (stat.is_count && stat.in_range)
                begin
                    state_next = blb_pkg::ST_MEM_RD;
                end
                else
                begin
                    state_next = blb_pkg::ST_FIN;
                end
            end
            blb_pkg::ST_SUM:
            begin
                if (stat.step_done)
                begin
                    state_next = stat.found ? blb_pkg::ST_DIV_GO : blb_pkg::ST_FIN;
                end
            end
            blb_pkg::ST_DIV_GO:
            begin
                state_next = blb_pkg::ST_DIV_WAIT;
            end
            blb_pkg::ST_DIV_WAIT:
            begin
                if (stat.div_done)
                begin
                    if (stat.mode == blb_pkg::MODE_RR || stat.mode == blb_pkg::MODE_HASH)
                    begin
                        state_next = blb_pkg::ST_PROBE;
                    end
                    else
                    begin
                        state_next = blb_pkg::ST_PICK;
                    end
                end
            end
            blb_pkg::ST_PROBE,
            blb_pkg::ST_PICK,
            blb_pkg::ST_LC:
            begin
                if (stat.step_done)
                begin
                    state_next = blb_pkg::ST_FIN;
                end
            end
            blb_pkg::ST_MEM_RD:
            begin
                state_next = blb_pkg::ST_MEM_WR;
            end
            blb_pkg::ST_MEM_WR:
            begin
                state_next = blb_pkg::ST_FIN;
            end
            blb_pkg::ST_FIN:
            begin
                if (stat.out_free)
                begin
                    state_next = blb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = blb_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.op   = blb_pkg::OP_NONE;
        in_stall = (state_reg != blb_pkg::ST_IDLE);
        unique case (state_reg)
            blb_pkg::ST_IDLE:     cmd.op = in_valid ? blb_pkg::OP_CAPTURE : blb_pkg::OP_NONE;
            blb_pkg::ST_DECODE:   cmd.op = blb_pkg::OP_CLEAR;
            blb_pkg::ST_DIV_GO:   cmd.op = blb_pkg::OP_DIV_GO;
            blb_pkg::ST_DIV_WAIT: cmd.op = blb_pkg::OP_NONE;
            blb_pkg::ST_PROBE:    cmd.op = blb_pkg::OP_PROBE;
            blb_pkg::ST_LC:       cmd.op = blb_pkg::OP_LC;
            blb_pkg::ST_SUM:      cmd.op = blb_pkg::OP_SUM;
            blb_pkg::ST_PICK:     cmd.op = blb_pkg::OP_PICK;
            blb_pkg::ST_MEM_RD:   cmd.op = blb_pkg::OP_MEM_RD;
            blb_pkg::ST_MEM_WR:   cmd.op = blb_pkg::OP_MEM_WR;
            blb_pkg::ST_FIN:      cmd.op = stat.out_free ? blb_pkg::OP_OUT : blb_pkg::OP_NONE;
            default:              cmd.op = blb_pkg::OP_NONE;
        endcase
    end

endmodule

>>> hw/rtl/blb_dp.sv
`timescale 1ns / 1ps
module blb_dp #(
    parameter int MAX_BACKENDS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  blb_pkg::ctrl_cmd_t                cmd,
    output blb_pkg::dp_stat_t                 stat,
    input  blb_pkg::in_item_t                 in_data,
    input  logic                              cfg_valid,
    input  logic [blb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [63:0]                       cfg_data,
    input  logic                              out_stall,
    output logic                              out_valid,
    output blb_pkg::out_item_t                out_data
);

    localparam int CW    = $clog2(MAX_BACKENDS + 1);
    localparam int IW    = $clog2(MAX_BACKENDS);
    localparam int DEPTH = (MAX_BACKENDS < blb_pkg::UP_W) ? MAX_BACKENDS : blb_pkg::UP_W;
    localparam int AW    = $clog2(DEPTH);

    // configuration
    logic                  en_reg;
    logic [2:0]            mode_reg;
    logic [4:0]            count_reg;
    logic [15:0]           mask_reg;
    logic [127:0]          wts_reg;

    // item and working state
    blb_pkg::in_item_t     item_reg;
    logic [IW-1:0]         ptr_reg;
    logic [IW-1:0]         idx_reg;
    logic [CW-1:0]         scan_reg;
    logic [CW-1:0]         seen_reg;
    logic [blb_pkg::SUM_W-1:0] acc_reg;
    logic [blb_pkg::SUM_W-1:0] rem_reg;
    logic                  cmp_v_reg;
    logic [CW-1:0]         cmp_idx_reg;
    logic                  best_v_reg;
    logic [CW-1:0]         best_idx_reg;
    logic [31:0]           least_reg;
    logic [DEPTH-1:0]      vld_reg;
    logic                  rvld_reg;
    logic                  res_v_reg;
    logic [3:0]            res_sel_reg;
    logic [31:0]           res_act_reg;
    logic [63:0]           res_tot_reg;
    logic                  out_valid_reg;
    blb_pkg::out_item_t    out_data_reg;

    logic [CW-1:0]         n;
    logic                  last;
    logic                  scan_up;
    logic                  idx_up;
    logic                  cmp_up;
    logic [blb_pkg::SUM_W-1:0] acc_add;
    logic [blb_pkg::SUM_W-1:0] acc_n;
    logic [IW-1:0]         idx_wrap;
    logic                  step_done;
    logic                  found;
    logic [AW-1:0]         raddr;
    logic                  mem_we;
    logic [31:0]           act_rdata;
    logic [63:0]           tot_rdata;
    logic [31:0]           act_cur;
    logic [63:0]           tot_cur;
    logic [31:0]           act_new;
    logic [63:0]           tot_new;
    logic [31:0]           lc_val;
    logic                  div_go;
    logic [blb_pkg::DIV_W-1:0] div_a;
    logic [blb_pkg::SUM_W-1:0] div_b;
    logic                  div_done;
    logic [blb_pkg::SUM_W-1:0] div_rem;

    function automatic logic up_at(input logic [CW-1:0] i, input logic [15:0] m);
        logic [7:0] ie;
        ie = 8'(i);
        return (ie < 8'd16) && m[ie[3:0]];
    endfunction

    function automatic logic [7:0] weight_at(input logic [CW-1:0] i, input logic [127:0] w);
        logic [7:0] ie;
        ie = 8'(i);
        return (ie < 8'd16) ? w[ie[3:0]*8 +: 8] : 8'd0;
    endfunction

    always_comb
    begin
        if ({27'd0, count_reg} > 32'(MAX_BACKENDS))
        begin
            n = CW'(MAX_BACKENDS);
        end
        else
        begin
            n = CW'(count_reg);
        end
    end

    assign last    = (scan_reg == n - CW'(1));
    assign scan_up = up_at(scan_reg, mask_reg);
    assign idx_up  = up_at(CW'(idx_reg), mask_reg);
    assign cmp_up  = up_at(cmp_idx_reg, mask_reg);

    // weighted sums weights, random counts up backends
    always_comb
    begin
        if (!scan_up)
        begin
            acc_add = '0;
        end
        else if (mode_reg == blb_pkg::MODE_WEIGHT)
        begin
            acc_add = blb_pkg::SUM_W'(weight_at(scan_reg, wts_reg));
        end
        else
        begin
            acc_add = blb_pkg::SUM_W'(1);
        end
    end
    assign acc_n = acc_reg + acc_add;

    assign idx_wrap = (CW'(idx_reg) + CW'(1) == n) ? '0 : IW'(CW'(idx_reg) + CW'(1));

    always_comb
    begin
        step_done = 1'b0;
        found     = 1'b0;
        case (cmd.op)
            blb_pkg::OP_PROBE:
            begin
                found     = idx_up;
                step_done = found || last;
            end
            blb_pkg::OP_SUM:
            begin
                found     = (acc_n != '0);
                step_done = last;
            end
            blb_pkg::OP_PICK:
            begin
                if (mode_reg == blb_pkg::MODE_WEIGHT)
                begin
                    found = scan_up && (rem_reg < acc_n);
                end
                else
                begin
                    found = scan_up && (blb_pkg::SUM_W'(seen_reg) == rem_reg);
                end
                step_done = found || last;
            end
            blb_pkg::OP_LC:
            begin
                step_done = (scan_reg == n) && !cmp_v_reg;
            end
            default:
            begin
                step_done = 1'b0;
            end
        endcase
    end

    assign stat.is_select = (item_reg.action == blb_pkg::ACT_SELECT);
    assign stat.is_count  = (item_reg.action == blb_pkg::ACT_START) ||
                            (item_reg.action == blb_pkg::ACT_END);
    assign stat.sel_none  = !en_reg || (n == '0) || (mode_reg > blb_pkg::MODE_RANDOM);
    assign stat.in_range  = (8'(item_reg.backend_index) < 8'(n));
    assign stat.mode      = mode_reg;
    assign stat.div_done  = div_done;
    assign stat.step_done = step_done;
    assign stat.found     = found;
    assign stat.out_free  = !out_valid_reg || !out_stall;

    // divider operands
    assign div_go = (cmd.op == blb_pkg::OP_DIV_GO);
    always_comb
    begin
        case (mode_reg)
            blb_pkg::MODE_RR:
            begin
                div_a = blb_pkg::DIV_W'(ptr_reg);
                div_b = blb_pkg::SUM_W'(n);
            end
            blb_pkg::MODE_HASH:
            begin
                div_a = item_reg.client_hash;
                div_b = blb_pkg::SUM_W'(n);
            end
            blb_pkg::MODE_RANDOM:
            begin
                div_a = {24'd0, item_reg.random_word[7:0]};
                div_b = acc_reg;
            end
            default:
            begin
                div_a = item_reg.random_word;
                div_b = acc_reg;
            end
        endcase
    end

    blb_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_go),
        .dividend  (div_a),
        .divisor   (div_b),
        .done      (div_done),
        .remainder (div_rem)
    );

    // counter memories
    assign raddr  = (cmd.op == blb_pkg::OP_LC) ? scan_reg[AW-1:0]
                                               : item_reg.backend_index[AW-1:0];
    assign mem_we = (cmd.op == blb_pkg::OP_MEM_WR);

    assign act_cur = rvld_reg ? act_rdata : 32'd0;
    assign tot_cur = rvld_reg ? tot_rdata : 64'd0;
    assign lc_val  = act_cur;

    always_comb
    begin
        if (item_reg.action == blb_pkg::ACT_START)
        begin
            act_new = (act_cur == blb_pkg::ACTIVE_SAT) ? act_cur : act_cur + 32'd1;
            tot_new = tot_cur + 64'd1;
        end
        else
        begin
            act_new = (act_cur == 32'd0) ? act_cur : act_cur - 32'd1;
            tot_new = tot_cur;
        end
    end

    blb_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_act_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (item_reg.backend_index[AW-1:0]),
        .wdata (act_new),
        .raddr (raddr),
        .rdata (act_rdata)
    );

    blb_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_tot_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (item_reg.backend_index[AW-1:0]),
        .wdata (tot_new),
        .raddr (raddr),
        .rdata (tot_rdata)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg        <= 1'b0;
            mode_reg      <= '0;
            count_reg     <= '0;
            mask_reg      <= '0;
            wts_reg       <= '0;
            ptr_reg       <= '0;
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    blb_pkg::REG_ENABLE:     en_reg          <= cfg_data[0];
                    blb_pkg::REG_MODE:       mode_reg        <= cfg_data[2:0];
                    blb_pkg::REG_COUNT:      count_reg       <= cfg_data[4:0];
                    blb_pkg::REG_UP_MASK:    mask_reg        <= cfg_data[15:0];
                    blb_pkg::REG_WEIGHTS_LO: wts_reg[63:0]   <= cfg_data;
                    blb_pkg::REG_WEIGHTS_HI: wts_reg[127:64] <= cfg_data;
                    default:                 en_reg          <= en_reg;
                endcase
            end
            if (cmd.op == blb_pkg::OP_PROBE && mode_reg == blb_pkg::MODE_RR)
            begin
                ptr_reg <= idx_wrap;
            end
            if (mem_we)
            begin
                vld_reg[item_reg.backend_index[AW-1:0]] <= 1'b1;
            end
            if (cmd.op == blb_pkg::OP_OUT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        rvld_reg <= vld_reg[raddr];
        if (div_done)
        begin
            idx_reg  <= IW'(div_rem);
            rem_reg  <= div_rem;
            scan_reg <= '0;
            acc_reg  <= '0;
            seen_reg <= '0;
        end
        case (cmd.op)
            blb_pkg::OP_CAPTURE:
            begin
                item_reg    <= in_data;
                res_v_reg   <= 1'b0;
                res_sel_reg <= '0;
                res_act_reg <= '0;
                res_tot_reg <= '0;
            end
            blb_pkg::OP_CLEAR:
            begin
                scan_reg   <= '0;
                acc_reg    <= '0;
                seen_reg   <= '0;
                cmp_v_reg  <= 1'b0;
                best_v_reg <= 1'b0;
            end
            blb_pkg::OP_PROBE:
            begin
                idx_reg  <= idx_wrap;
                scan_reg <= scan_reg + CW'(1);
                if (found)
                begin
                    res_v_reg   <= 1'b1;
                    res_sel_reg <= 4'(idx_reg);
                end
            end
            blb_pkg::OP_SUM:
            begin
                acc_reg  <= acc_n;
                scan_reg <= scan_reg + CW'(1);
            end
            blb_pkg::OP_PICK:
            begin
                acc_reg  <= acc_n;
                scan_reg <= scan_reg + CW'(1);
                if (scan_up)
                begin
                    seen_reg <= seen_reg + CW'(1);
                end
                if (found)
                begin
                    res_v_reg   <= 1'b1;
                    res_sel_reg <= 4'(scan_reg);
                end
            end
            blb_pkg::OP_LC:
            begin
                // read data compared in the cycle after the read is issued
                if (scan_reg < n)
                begin
                    cmp_v_reg   <= 1'b1;
                    cmp_idx_reg <= scan_reg;
                    scan_reg    <= scan_reg + CW'(1);
                end
                else
                begin
                    cmp_v_reg <= 1'b0;
                end
                if (cmp_v_reg && cmp_up && (!best_v_reg || lc_val < least_reg))
                begin
                    best_v_reg   <= 1'b1;
                    best_idx_reg <= cmp_idx_reg;
                    least_reg    <= lc_val;
                end
                if (step_done)
                begin
                    res_v_reg   <= best_v_reg;
                    res_sel_reg <= best_v_reg ? 4'(best_idx_reg) : 4'd0;
                end
            end
            blb_pkg::OP_MEM_WR:
            begin
                res_act_reg <= act_new;
                res_tot_reg <= tot_new;
            end
            blb_pkg::OP_OUT:
            begin
                out_data_reg.selection_valid  <= res_v_reg;
                out_data_reg.selected_backend <= res_sel_reg;
                out_data_reg.active_count_now <= res_act_reg;
                out_data_reg.total_count_now  <= res_tot_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> hw/rtl/backend_load_balancer_unit.sv
`timescale 1ns / 1ps
// Backend load balancer: one request beat in, one result beat out, one item in
// flight at a time. Connection start and end go through the counter memories
// (read, update, write back). Least connections does one memory read per
// configured backend, n being the configured backend count. Round robin, client
// hash, weighted and random selections go through a bit-serial 32-bit remainder
// unit plus a scan of up to n backends after it, and weighted and random also
// scan before it. Counters clear at reset with no sweep. A finished result sits
// in the output register while the next beat is taken.
module backend_load_balancer_unit #(
    parameter int MAX_BACKENDS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  blb_pkg::in_item_t             in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output blb_pkg::out_item_t            out_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [blb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                   cfg_data
);

    blb_pkg::ctrl_cmd_t cmd;
    blb_pkg::dp_stat_t  stat;

    assign cfg_ready = 1'b1;

    blb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    blb_dp #(.MAX_BACKENDS(MAX_BACKENDS)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (in_data),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

>>> hw/rtl/blb_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module blb_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input blb_pkg::out_item_t out_data
);

    // stalled result beat holds
    `BLB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
    // no selection always reports backend zero
    `BLB_ASSERT(a_none_zero, out_valid && !out_data.selection_valid, out_data.selected_backend == 4'd0)
    // a selection carries no counts
    `BLB_ASSERT(a_sel_counts, out_valid && out_data.selection_valid, out_data.active_count_now == 32'd0 && out_data.total_count_now == 64'd0)
    // one item at a time
    `BLB_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

endmodule

bind backend_load_balancer_unit blb_checker u_blb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
